@@ rtl/core/sfl_pkg.sv @@
package sfl_pkg;

  localparam int LINK_W = 16;
  localparam logic [LINK_W-1:0] END_MARK = 16'hFFFF;
  localparam logic [8:0] COUNT_MAX = 9'h1FF;

  // command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  // list class codes
  localparam logic [1:0] CLASS_EMPTY   = 2'd0;
  localparam logic [1:0] CLASS_PARTIAL = 2'd1;
  localparam logic [1:0] CLASS_FULL    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SLOT_COUNT = 2'd0;
  localparam logic [1:0] REG_OBJ_SIZE   = 2'd1;
  localparam logic [1:0] REG_BASE_ADDR  = 2'd2;

  localparam logic [8:0] MUL_LAST = 9'd15;
  localparam logic [8:0] DIV_LAST = 9'd31;

endpackage

@@ rtl/core/sfl_ram.sv @@
module sfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/slab_slot_free_list.sv @@
// Slot manager for one slab, kept as an index-linked free list.
// Input channel in_*: one command per transfer (allocate, free, initialize).
// Output channel out_*: exactly one result per command, in order.
// Configuration: cfg_wen writes register cfg_index (0 slot count, 1 object
// size, 2 base address) at the clock edge; write only while the block idles.
// Command flow: one command at a time, the input is not ready
// while a command is in progress. Allocate runs a 16-step shift-add
// multiply of the slot index by the object size, free an offset
// subtract plus a 32-step restoring divide, initialize one link write
// per slot into the single write port of the link store.
// The multiply, offset subtract and divide share one 33-bit add/subtract unit.
// A finished result sits in the output register; the next command is taken
// meanwhile, but its result waits while the receiver stalls out_tready.
// Reset (rst_n low, synchronous): empty list (head is the end marker), zero
// in-use count, registers to slot count 1, object size 32, base 0. The link
// store is not cleared; an allocate before initialize fails.
module slab_slot_free_list
  import sfl_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[1:0], obj_addr[33:2], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // result_addr[31:0], ok[32], list_class[34:33],
                                  // in_use[43:35], zero pad
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = $clog2(SLOTS);
  localparam logic [16:0] SLOTS_W = 17'(SLOTS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_OFFS = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_INIT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] mcand_r, mcand_nxt;
  logic [15:0] mplier_r, mplier_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [8:0]  used_r, used_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;
  logic        res_ok_r, res_ok_nxt;

  logic [8:0]  slot_count_r;
  logic [17:0] obj_size_r;
  logic [31:0] base_addr_r;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  logic        out_ok_r, out_ok_nxt;
  logic [1:0]  out_class_r, out_class_nxt;
  logic [8:0]  out_used_r, out_used_nxt;

  // shared add/subtract unit
  logic [31:0] op_a, op_b;
  logic        op_sub;
  logic [32:0] sum;

  logic [8:0]  live_n;
  logic [18:0] div_t;
  logic        qbit;
  logic [31:0] quot;
  logic [9:0]  cnt_inc;
  logic [1:0]  class_now;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  sfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign live_n = ({8'b0, slot_count_r} > SLOTS_W) ? SLOTS_W[8:0] : slot_count_r;
  assign div_t  = {rem_r, acc_r[31]};
  assign sum    = {1'b0, op_a} + {1'b0, op_b ^ {32{op_sub}}} + {32'b0, op_sub};
  assign qbit   = sum[32];
  assign quot   = {acc_r[30:0], qbit};
  assign cnt_inc = {1'b0, cnt_r} + 10'd1;

  always_comb begin
    op_a   = acc_r;
    op_b   = mcand_r;
    op_sub = 1'b0;
    unique case (state_r)
      S_OFFS: begin
        op_a   = addr_r;
        op_b   = base_addr_r;
        op_sub = 1'b1;
      end
      S_DIV: begin
        op_a   = {13'b0, div_t};
        op_b   = {14'b0, obj_size_r};
        op_sub = 1'b1;
      end
      default: begin
        op_a   = acc_r;
        op_b   = mcand_r;
        op_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (used_r == 9'd0) begin
      class_now = CLASS_EMPTY;
    end else if (head_r == END_MARK) begin
      class_now = CLASS_FULL;
    end else begin
      class_now = CLASS_PARTIAL;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    addr_nxt     = addr_r;
    acc_nxt      = acc_r;
    mcand_nxt    = mcand_r;
    mplier_nxt   = mplier_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    used_nxt     = used_r;
    res_addr_nxt = res_addr_r;
    res_ok_nxt   = res_ok_r;
    ram_we       = 1'b0;
    ram_waddr    = head_r[AW-1:0];
    ram_wdata    = head_r;

    out_valid_nxt = out_valid_r && !out_tready;
    out_addr_nxt  = out_addr_r;
    out_ok_nxt    = out_ok_r;
    out_class_nxt = out_class_r;
    out_used_nxt  = out_used_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt      = in_tdata[1:0];
          addr_nxt     = in_tdata[33:2];
          res_addr_nxt = 32'd0;
          res_ok_nxt   = 1'b0;
          cnt_nxt      = 9'd0;
          state_nxt    = S_DONE;
          priority if (in_tdata[1:0] == CMD_ALLOC) begin
            if (head_r != END_MARK && {1'b0, head_r} < SLOTS_W) begin
              acc_nxt    = base_addr_r;
              mcand_nxt  = {14'b0, obj_size_r};
              mplier_nxt = head_r;
              state_nxt  = S_MUL;
            end
          end else if (in_tdata[1:0] == CMD_FREE) begin
            if (obj_size_r != 18'd0) begin
              state_nxt = S_OFFS;
            end
          end else if (in_tdata[1:0] == CMD_INIT) begin
            if (live_n == 9'd0) begin
              head_nxt   = END_MARK;
              used_nxt   = 9'd0;
              res_ok_nxt = 1'b1;
            end else begin
              state_nxt = S_INIT;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_OFFS: begin
        acc_nxt   = sum[31:0];
        rem_nxt   = 18'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem_nxt = qbit ? sum[17:0] : div_t[17:0];
        acc_nxt = quot;
        cnt_nxt = cnt_inc[8:0];
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_DONE;
          if (quot[31:9] == 23'd0 && quot[8:0] < live_n) begin
            ram_we     = 1'b1;
            ram_waddr  = quot[AW-1:0];
            ram_wdata  = head_r;
            head_nxt   = quot[LINK_W-1:0];
            used_nxt   = (used_r != 9'd0) ? used_r - 9'd1 : used_r;
            res_ok_nxt = 1'b1;
          end
        end
      end
      S_MUL: begin
        // shift-add multiply, link of the head is read meanwhile
        if (mplier_r[0]) begin
          acc_nxt = sum[31:0];
        end
        mcand_nxt  = {mcand_r[30:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[15:1]};
        cnt_nxt    = cnt_inc[8:0];
        if (cnt_r == MUL_LAST) begin
          res_addr_nxt = mplier_r[0] ? sum[31:0] : acc_r;
          res_ok_nxt   = 1'b1;
          head_nxt     = ram_rdata;
          used_nxt     = (used_r != COUNT_MAX) ? used_r + 9'd1 : used_r;
          state_nxt    = S_DONE;
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt_r);
        ram_wdata = (cnt_inc < {1'b0, live_n}) ? LINK_W'(cnt_inc) : END_MARK;
        cnt_nxt   = cnt_inc[8:0];
        if (cnt_inc == {1'b0, live_n}) begin
          head_nxt   = '0;
          used_nxt   = 9'd0;
          res_ok_nxt = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_ok_nxt    = res_ok_r;
          out_class_nxt = class_now;
          out_used_nxt  = used_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= END_MARK;
      used_r       <= 9'd0;
      out_valid_r  <= 1'b0;
      slot_count_r <= 9'd1;
      obj_size_r   <= 18'd32;
      base_addr_r  <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_SLOT_COUNT: slot_count_r <= cfg_wdata[8:0];
          REG_OBJ_SIZE:   obj_size_r   <= cfg_wdata[17:0];
          REG_BASE_ADDR:  base_addr_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    addr_r      <= addr_nxt;
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    res_addr_r  <= res_addr_nxt;
    res_ok_r    <= res_ok_nxt;
    out_addr_r  <= out_addr_nxt;
    out_ok_r    <= out_ok_nxt;
    out_class_r <= out_class_nxt;
    out_used_r  <= out_used_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_used_r, out_class_r, out_ok_r, out_addr_r};

  // the head is either the end marker or a slot inside the store
  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == END_MARK) || ({1'b0, head_r} < SLOTS_W))
    else $error("free head outside the slot range");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_addr_r == 32'd0))
    else $error("failed command returned a nonzero address");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented without a finished command");

  a_full_has_users: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_class_r == CLASS_FULL) |-> (out_used_r != 9'd0))
    else $error("full class reported with no slot in use");

  a_cmd_kept: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV) || (state_r == S_OFFS)) |-> (cmd_r == CMD_FREE))
    else $error("divide running for a command other than free");

endmodule

@@ test/slab_slot_free_list_test.sv @@
module slab_slot_free_list_test;
  import sfl_pkg::*;

  localparam int NSLOTS = 256;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 30;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [8:0]  cnt;
    logic [1:0]  cls;
    logic        ok;
    logic [31:0] addr;
  } slot_result_t;

  typedef struct {
    logic         is_cfg;
    logic [1:0]   code;
    logic [31:0]  val;
    logic         typed;
    slot_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // cmd[1:0], obj_addr[33:2], zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // result_addr[31:0], ok[32], list_class[34:33], in_use[43:35], pad
  logic        cfg_wen;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  // free list mirror
  logic [15:0] link_mem [NSLOTS];
  logic [15:0] head;
  logic [8:0]  used;
  logic [8:0]  cfg_slots;
  logic [17:0] cfg_size;
  logic [31:0] cfg_base;

  slot_result_t slot_results_due [$];
  logic [31:0]  live_addrs [$];
  stim_row_t    dir_rows [$];

  int err_count = 0;
  int reports = 0;
  int quiet_cycles = 0;
  int send_idle = 20;
  int take_idle = 54;

  slab_slot_free_list #(.SLOTS(NSLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [8:0] live_slots();
    return (cfg_slots > 9'(NSLOTS)) ? 9'(NSLOTS) : cfg_slots;
  endfunction

  // applies one command to the mirror and returns the result it yields
  function automatic slot_result_t step_free_list(input logic [1:0] c, input logic [31:0] a);
    slot_result_t r;
    logic [63:0]  prod;
    logic [31:0]  off;
    logic [31:0]  idx;
    logic [8:0]   n;
    int           i;
    r = '0;
    n = live_slots();
    case (c)
      CMD_ALLOC: begin
        if (head != END_MARK && head < 16'(NSLOTS)) begin
          prod = 64'(cfg_base) + 64'(head) * 64'(cfg_size);
          r.addr = prod[31:0];
          head = link_mem[head[7:0]];
          if (used != COUNT_MAX) used = used + 9'd1;
          r.ok = 1'b1;
        end
      end
      CMD_FREE: begin
        if (cfg_size != 18'd0) begin
          off = a - cfg_base;
          idx = off / 32'(cfg_size);
          if (idx < 32'(n)) begin
            link_mem[idx[7:0]] = head;
            head = idx[15:0];
            if (used != 9'd0) used = used - 9'd1;
            r.ok = 1'b1;
          end
        end
      end
      CMD_INIT: begin
        for (i = 0; i < int'(n); i++)
          link_mem[i] = (i + 1 < int'(n)) ? 16'(i + 1) : END_MARK;
        head = (n != 9'd0) ? 16'd0 : END_MARK;
        used = 9'd0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.cls = (used == 9'd0) ? CLASS_EMPTY : (head == END_MARK) ? CLASS_FULL : CLASS_PARTIAL;
    r.cnt = used;
    return r;
  endfunction

  function automatic void add_cmd(input logic [1:0] c, input logic [31:0] a);
    dir_rows.push_back('{1'b0, c, a, 1'b0, '0});
  endfunction

  function automatic void add_typed(input logic [1:0] c, input logic [31:0] a,
                                    input logic ok, input logic [1:0] cls,
                                    input logic [8:0] cnt);
    slot_result_t r;
    r.addr = 32'd0;
    r.ok = ok;
    r.cls = cls;
    r.cnt = cnt;
    dir_rows.push_back('{1'b0, c, a, 1'b1, r});
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] v);
    dir_rows.push_back('{1'b1, idx, v, 1'b0, '0});
  endfunction

  task automatic send_cmd(input logic [1:0] c, input logic [31:0] a, input logic typed,
                          input slot_result_t typed_res, output slot_result_t res);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, a, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = step_free_list(c, a);
    slot_results_due.push_back(typed ? typed_res : res);
  endtask

  // block is idle once every result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (slot_results_due.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      REG_SLOT_COUNT: cfg_slots = v[8:0];
      REG_OBJ_SIZE:   cfg_size = v[17:0];
      REG_BASE_ADDR:  cfg_base = v;
      default: ;
    endcase
  endtask

  task automatic random_cmd();
    slot_result_t r;
    int           pick;
    int           j;
    logic [1:0]   c;
    logic [31:0]  a;
    logic [31:0]  off;
    pick = $urandom_range(99);
    a = $urandom;
    off = (cfg_size > 18'd1) ? 32'($urandom_range(32'(cfg_size) - 1)) : 32'd0;
    if (pick < 5) c = CMD_INIT;
    else if (pick < 8) c = CMD_UNKNOWN;
    else if (pick < 50 || (pick < 82 && live_addrs.size() == 0)) c = CMD_ALLOC;
    else begin
      c = CMD_FREE;
      if (pick < 82) begin
        j = $urandom_range(live_addrs.size() - 1);
        a = live_addrs[j] + off;
        live_addrs.delete(j);
      end else if (pick < 92) begin
        // any slot, one past the end included
        a = cfg_base + 32'($urandom_range(32'(live_slots()))) * 32'(cfg_size) + off;
      end
    end
    send_cmd(c, a, 1'b0, '0, r);
    if (c == CMD_INIT) live_addrs.delete();
    else if (c == CMD_ALLOC && r.ok) live_addrs.push_back(r.addr);
  endtask

  // result side: ready pattern, checking and watchdog
  always @(posedge clk) begin
    slot_result_t got;
    slot_result_t want;
    got = out_tdata[43:0];
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (out_tvalid && out_tready) begin
      if (slot_results_due.size() == 0) begin
        err_count++;
        if (reports++ < MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got %h", $time, got);
      end else begin
        want = slot_results_due.pop_front();
        if (got !== want) begin
          err_count++;
          if (reports++ < MAX_REPORTS) begin
            if (got.addr !== want.addr)
              $display("%0t: result_addr expected %h got %h", $time, want.addr, got.addr);
            if (got.ok !== want.ok)
              $display("%0t: ok expected %b got %b", $time, want.ok, got.ok);
            if (got.cls !== want.cls)
              $display("%0t: list_class expected %0d got %0d", $time, want.cls, got.cls);
            if (got.cnt !== want.cnt)
              $display("%0t: in_use expected %0d got %0d", $time, want.cnt, got.cnt);
          end
        end
      end
    end
    out_tready <= ($urandom_range(99) >= take_idle);
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[slab_slot_free_list] ERROR");
      $finish;
    end
  end

  initial begin
    slot_result_t r;
    int           ph;
    int           k;
    logic [31:0]  v_slots;
    logic [31:0]  v_size;
    logic [31:0]  v_base;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wen = 1'b0;
    cfg_index = REG_SLOT_COUNT;
    cfg_wdata = '0;
    head = END_MARK;
    used = 9'd0;
    cfg_slots = 9'd1;
    cfg_size = 18'd32;
    cfg_base = 32'd0;
    for (k = 0; k < NSLOTS; k++) link_mem[k] = 16'd0;

    // reset state: one slot of 32 bytes at address 0
    add_typed(CMD_ALLOC, 32'd0, 1'b0, CLASS_EMPTY, 9'd0);          // before init
    add_typed(CMD_UNKNOWN, 32'hFFFF_FFFF, 1'b0, CLASS_EMPTY, 9'd0);
    add_typed(CMD_INIT, 32'd0, 1'b1, CLASS_EMPTY, 9'd0);
    dir_rows.push_back('{1'b0, CMD_ALLOC, 32'd0, 1'b1, '{9'd1, CLASS_FULL, 1'b1, 32'd0}});
    add_typed(CMD_ALLOC, 32'd0, 1'b0, CLASS_FULL, 9'd1);           // slab full
    add_typed(CMD_FREE, 32'd32, 1'b0, CLASS_FULL, 9'd1);           // index past end
    add_cmd(CMD_FREE, 32'd31);                                     // truncated offset
    add_cmd(CMD_FREE, 32'd0);                                      // double free
    add_cmd(CMD_ALLOC, 32'd0);
    add_cmd(CMD_ALLOC, 32'd0);
    // empty chain
    add_cfg(REG_SLOT_COUNT, 32'd0);
    add_typed(CMD_INIT, 32'd0, 1'b1, CLASS_EMPTY, 9'd0);
    add_typed(CMD_ALLOC, 32'd0, 1'b0, CLASS_EMPTY, 9'd0);
    add_typed(CMD_FREE, 32'd0, 1'b0, CLASS_EMPTY, 9'd0);
    // slot count above the store size, objects of 131072 bytes, addresses wrap
    add_cfg(REG_SLOT_COUNT, 32'd511);
    add_cfg(REG_OBJ_SIZE, 32'd131072);
    add_cfg(REG_BASE_ADDR, 32'hFFFF_FFF0);
    add_typed(CMD_INIT, 32'd0, 1'b1, CLASS_EMPTY, 9'd0);
    add_cmd(CMD_ALLOC, 32'd0);
    add_cmd(CMD_ALLOC, 32'd0);
    add_cmd(CMD_FREE, 32'h8000_0000);
    add_cmd(CMD_FREE, 32'hFFFF_FFFF);
    add_cmd(CMD_FREE, 32'h0002_0000);
    // zero object size
    add_cfg(REG_OBJ_SIZE, 32'd0);
    add_cmd(CMD_FREE, 32'd0);
    add_cmd(CMD_ALLOC, 32'd0);
    // 4-byte objects, address below base
    add_cfg(REG_OBJ_SIZE, 32'd4);
    add_cfg(REG_BASE_ADDR, 32'h0000_1000);
    add_cfg(REG_SLOT_COUNT, 32'd256);
    add_typed(CMD_INIT, 32'd0, 1'b1, CLASS_EMPTY, 9'd0);
    add_cmd(CMD_FREE, 32'h0000_0FFC);
    add_cmd(CMD_FREE, 32'h0000_13FC);
    add_cmd(CMD_FREE, 32'h0000_1400);
    add_cmd(CMD_ALLOC, 32'd0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        write_reg(dir_rows[i].code, dir_rows[i].val);
      end else begin
        cfg_wen <= 1'b0;
        send_cmd(dir_rows[i].code, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res, r);
      end
    end

    for (ph = 0; ph < 9; ph++) begin
      wait_drained();
      if (ph < 3) begin
        send_idle = 20;
        take_idle = 54;
      end else if (ph < 6) begin
        send_idle = 54;
        take_idle = 20;
      end else begin
        send_idle = 0;
        take_idle = 0;
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4: v_slots = $urandom_range(12, 2);
        5, 6:          v_slots = $urandom_range(256, 1);
        7:             v_slots = 32'd256;
        8:             v_slots = $urandom_range(511, 257);
        default:       v_slots = 32'd0;
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: v_size = 32'd4 * $urandom_range(64, 1);
        6, 7:             v_size = 32'd4 * $urandom_range(32768, 1);
        8:                v_size = $urandom_range(262143, 1);
        default:          v_size = 32'd131072;
      endcase
      case ($urandom_range(9))
        7:       v_base = 32'd0;
        8:       v_base = 32'hFFFF_FFFF;
        9:       v_base = 32'hFFFF_0000;
        default: v_base = $urandom;
      endcase
      // extremes first
      if (ph == 0) begin
        v_slots = 32'd1;
        v_size = 32'd4;
        v_base = 32'd0;
      end else if (ph == 1) begin
        v_slots = 32'd256;
        v_size = 32'd131072;
        v_base = 32'hFFFF_FFFF;
      end
      write_reg(REG_SLOT_COUNT, v_slots);
      write_reg(REG_OBJ_SIZE, v_size);
      write_reg(REG_BASE_ADDR, v_base);
      cfg_wen <= 1'b0;
      live_addrs.delete();
      send_cmd(CMD_INIT, $urandom, 1'b0, '0, r);
      for (k = 0; k < 160; k++) random_cmd();
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (err_count == 0 && slot_results_due.size() == 0)
      $display("[slab_slot_free_list] OK");
    else
      $display("[slab_slot_free_list] ERROR");
    $finish;
  end

endmodule
